// File: rtl/refcounted_lock_table_defines.svh
// Assertion macros for the lock table.
// RCLT_ASSERT_IMP checks a same-cycle implication, RCLT_ASSERT_NXT a next-cycle one.
`ifndef REFCOUNTED_LOCK_TABLE_DEFINES_SVH
`define REFCOUNTED_LOCK_TABLE_DEFINES_SVH

`ifndef SYNTH
`define RCLT_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock table check failed");
`define RCLT_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock table check failed");
`else
`define RCLT_ASSERT_IMP(name, clk, rst, ante, cons)
`define RCLT_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// File: rtl/rclt_pkg.sv
package rclt_pkg;

   // table geometry
   localparam int ENTRIES   = 64;
   localparam int COUNT_MAX = 65535;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int SCAN_W    = $clog2(ENTRIES + 1);
   localparam int KEY_W     = 64;
   localparam int CNT_W     = 16;

   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(COUNT_MAX);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   // request kinds (the unused code behaves as a query)
   localparam logic [1:0] KIND_LOCK   = 2'd0;
   localparam logic [1:0] KIND_UNLOCK = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_AT_MAX = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] tile_key;
   } req_type;

   typedef struct packed {
      logic             answer;
      logic [1:0]       status;
      logic [CNT_W-1:0] lock_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } stat_type;

endpackage

// File: rtl/refcounted_lock_table.sv
// Channel   Handshake                  Payload
// request   start in, busy out         req_item  (kind, tile_key)
// response  rsp_valid out, one cycle   rsp_item  (answer, status, lock_count)
//
// A transaction runs from start to rsp_valid through a load step, a scan over every entry
// through the registered memory read port plus a compare step, a done step and an update
// step. busy falls in the cycle rsp_valid is high, so the next start is taken then.
// reset is synchronous and active high; it frees every entry at once.
// The receiver cannot stall: each response is shown for exactly one cycle.
`include "refcounted_lock_table_defines.svh"
module refcounted_lock_table
   import rclt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   cmd_type  cmd;
   stat_type stat;

   rclt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   rclt_data u_data (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .stat      (stat),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

   // an accepted transaction keeps the block busy
   `RCLT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // every response follows an update cycle
   `RCLT_ASSERT_IMP(a_rsp_after_update, clock, reset, rsp_valid, $past(cmd.update))
   // a flagged condition never reports success
   `RCLT_ASSERT_IMP(a_flag_no_answer, clock, reset,
      rsp_valid && (rsp_item.status != STAT_OK), !rsp_item.answer)
   // the block is idle while a response is shown
   `RCLT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)

endmodule

// File: rtl/rclt_ctrl.sv
module rclt_ctrl
   import rclt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequence one transaction: load, scan the table, update
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/rclt_data.sv
module rclt_data
   import rclt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  req_type  req_item,
   output stat_type stat,
   output rsp_type  rsp_item,
   output logic     rsp_valid
);

   // table storage; occupancy flags mark live entries, so a free entry never matches
   logic [KEY_W-1:0]  key_mem_ff [ENTRIES];
   logic [CNT_W-1:0]  cnt_mem_ff [ENTRIES];
   logic [ENTRIES-1:0] occ_ff;

   req_type           req_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [KEY_W-1:0]  key_rd_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic              occ_rd_ff;
   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [CNT_W-1:0]  hit_cnt_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              rsp_valid_ff;

   logic              issue;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_key;
   logic              wr_cnt;
   logic [IDX_W-1:0]  wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic              set_occ;
   logic              clr_occ;

   assign issue   = cmd.scan && (scan_ff != SCAN_W'(ENTRIES));
   assign rd_addr = scan_ff[IDX_W-1:0];
   assign stat.scan_done = cmd.scan && (scan_ff == SCAN_W'(ENTRIES)) && !rd_valid_ff;

   // capture request, advance scan address
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         if (cmd.load) begin
            scan_ff <= '0;
         end else if (issue) begin
            scan_ff <= scan_ff + SCAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (issue) begin
         rd_idx_ff <= rd_addr;
         occ_rd_ff <= occ_ff[rd_addr];
      end
   end

   // registered reads and single write port of each memory
   always_ff @(posedge clock) begin
      if (issue) begin
         key_rd_ff <= key_mem_ff[rd_addr];
      end
      if (wr_key) begin
         key_mem_ff[wr_addr] <= req_ff.tile_key;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         cnt_rd_ff <= cnt_mem_ff[rd_addr];
      end
      if (wr_cnt) begin
         cnt_mem_ff[wr_addr] <= wr_data;
      end
   end

   // track first matching entry and lowest free entry
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_valid_ff) begin
         if (occ_rd_ff && (key_rd_ff == req_ff.tile_key) && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!occ_rd_ff && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff && occ_rd_ff && (key_rd_ff == req_ff.tile_key) && !hit_ff) begin
         hit_idx_ff <= rd_idx_ff;
         hit_cnt_ff <= cnt_rd_ff;
      end
      if (rd_valid_ff && !occ_rd_ff && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // decide the outcome and table writes
   always_comb begin
      rsp_in  = '0;
      wr_key  = 1'b0;
      wr_cnt  = 1'b0;
      wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_data = CNT_ONE;
      set_occ = 1'b0;
      clr_occ = 1'b0;
      case (req_ff.kind)
         KIND_LOCK: begin
            if (hit_ff) begin
               if (hit_cnt_ff >= CNT_LIMIT) begin
                  rsp_in.status     = STAT_AT_MAX;
                  rsp_in.lock_count = hit_cnt_ff;
               end else begin
                  wr_data           = hit_cnt_ff + CNT_ONE;
                  wr_cnt            = cmd.update;
                  rsp_in.lock_count = hit_cnt_ff + CNT_ONE;
               end
            end else if (free_ff) begin
               wr_key            = cmd.update;
               wr_cnt            = cmd.update;
               set_occ           = cmd.update;
               rsp_in.answer     = 1'b1;
               rsp_in.lock_count = CNT_ONE;
            end else begin
               rsp_in.status = STAT_FULL;
            end
         end
         KIND_UNLOCK: begin
            if (hit_ff) begin
               if (hit_cnt_ff == CNT_ONE) begin
                  clr_occ       = cmd.update;
                  rsp_in.answer = 1'b1;
               end else begin
                  wr_data           = hit_cnt_ff - CNT_ONE;
                  wr_cnt            = cmd.update;
                  rsp_in.lock_count = hit_cnt_ff - CNT_ONE;
               end
            end
         end
         KIND_QUERY: begin
            rsp_in.answer     = hit_ff;
            rsp_in.lock_count = hit_ff ? hit_cnt_ff : '0;
         end
         default: begin
            rsp_in.answer     = hit_ff;
            rsp_in.lock_count = hit_ff ? hit_cnt_ff : '0;
         end
      endcase
   end

   // update occupancy and drive the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
         if (set_occ) begin
            occ_ff[wr_addr] <= 1'b1;
         end else if (clr_occ) begin
            occ_ff[wr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: bench/refcounted_lock_table_checker.sv
module refcounted_lock_table_checker
   import rclt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      mismatches,
   output int      outstanding
);

   // shadow copy of the lock table
   logic [KEY_W-1:0] held_key [ENTRIES];
   logic [CNT_W-1:0] held_cnt [ENTRIES];

   // responses still owed by the block, oldest first
   rsp_type owed_rsp_q[$];

   // apply one transaction to the shadow table and return its response
   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int hit;
      int slot;
      res = '0;
      res.status = STAT_OK;
      hit = -1;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && held_cnt[i] != '0 && held_key[i] == r.tile_key)
            hit = i;
         if (slot < 0 && held_cnt[i] == '0)
            slot = i;
      end
      case (r.kind)
         KIND_LOCK: begin
            if (hit >= 0) begin
               if (held_cnt[hit] >= CNT_LIMIT) begin
                  res.status = STAT_AT_MAX;
               end else begin
                  held_cnt[hit] = held_cnt[hit] + CNT_ONE;
               end
               res.lock_count = held_cnt[hit];
            end else if (slot < 0) begin
               res.status = STAT_FULL;
            end else begin
               held_key[slot] = r.tile_key;
               held_cnt[slot] = CNT_ONE;
               res.answer = 1'b1;
               res.lock_count = CNT_ONE;
            end
         end
         KIND_UNLOCK: begin
            if (hit >= 0) begin
               held_cnt[hit] = held_cnt[hit] - CNT_ONE;
               res.lock_count = held_cnt[hit];
               res.answer = (held_cnt[hit] == '0);
            end
         end
         // query, and the spare code that behaves as one
         default: begin
            if (hit >= 0) begin
               res.answer = 1'b1;
               res.lock_count = held_cnt[hit];
            end
         end
      endcase
      return res;
   endfunction

   // print one mismatch line and count it
   task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   // compare responses, then predict accepted transactions
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         owed_rsp_q.delete();
         for (int i = 0; i < ENTRIES; i++) begin
            held_key[i] = '0;
            held_cnt[i] = '0;
         end
         mismatches = 0;
      end else begin
         if (rsp_valid) begin
            if (owed_rsp_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_item.lock_count, '0);
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_item.answer !== want.answer)
                  report_mismatch("answer", CNT_W'(rsp_item.answer), CNT_W'(want.answer));
               if (rsp_item.status !== want.status)
                  report_mismatch("status", CNT_W'(rsp_item.status), CNT_W'(want.status));
               if (rsp_item.lock_count !== want.lock_count)
                  report_mismatch("lock_count", rsp_item.lock_count, want.lock_count);
            end
         end
         if (start && !busy)
            owed_rsp_q.push_back(apply_request(req_item));
      end
      outstanding = owed_rsp_q.size();
   end

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

endmodule

// File: bench/refcounted_lock_table_tb.sv
module refcounted_lock_table_tb;
   import rclt_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int POOL_SIZE = 70;
   localparam int PHASE_ITEMS = 384;
   localparam int MAX_GAP = 90;
   localparam int CYCLE_LIMIT = 1200 * (ENTRIES + 4 + MAX_GAP + 2) * 3;
   localparam logic [KEY_W-1:0] ALL_ONES = '1;
   localparam logic [KEY_W-1:0] TOP_BIT = {1'b1, {(KEY_W-1){1'b0}}};

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      mismatches;
   int      outstanding;
   int      cycle_count;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int  idle_pct;
   bit  filling;
   int  segment_left;

   refcounted_lock_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   refcounted_lock_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("refcounted_lock_table test failed");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] fresh_key();
      return {$urandom, $urandom};
   endfunction

   // hold one transaction until it is taken; return at the falling edge after it
   task automatic issue(logic [1:0] kind, logic [KEY_W-1:0] key);
      start <= 1'b1;
      req_item <= '{kind: kind, tile_key: key};
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // drop start cycle by cycle, each cycle idle at the current idle rate
   task automatic sender_gap();
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // pick one random transaction, biased to fill or drain the table
   task automatic issue_random();
      int r;
      logic [1:0] kind;
      logic [KEY_W-1:0] key;
      if (segment_left == 0) begin
         filling = !filling;
         segment_left = $urandom_range(60, 180);
      end
      segment_left--;
      r = $urandom_range(99);
      if (filling)
         kind = (r < 80) ? KIND_LOCK : (r < 90) ? KIND_UNLOCK : (r < 97) ? KIND_QUERY : KIND_SPARE;
      else
         kind = (r < 20) ? KIND_LOCK : (r < 80) ? KIND_UNLOCK : (r < 95) ? KIND_QUERY : KIND_SPARE;
      key = ($urandom_range(99) < 92) ? key_pool[$urandom_range(POOL_SIZE - 1)] : fresh_key();
      issue(kind, key);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      cycle_count = 0;
      idle_pct = 0;
      filling = 1'b0;
      segment_left = 0;

      // build a key pool with near-miss neighbors
      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      for (int i = 2; i < POOL_SIZE; i++) begin
         if (i % 3 == 0)
            key_pool[i] = key_pool[i - 1] ^ (KEY_W'(1) << $urandom_range(KEY_W - 1));
         else
            key_pool[i] = fresh_key();
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, every kind, absent keys, one-bit near misses
      issue(KIND_LOCK, '0);
      issue(KIND_LOCK, ALL_ONES);
      issue(KIND_LOCK, '0);
      issue(KIND_QUERY, '0);
      issue(KIND_QUERY, {32'h5555_5555, 32'haaaa_aaaa});
      issue(KIND_SPARE, ALL_ONES);
      issue(KIND_SPARE, 64'h0123_4567_89ab_cdef);
      issue(KIND_UNLOCK, 64'ha5a5_a5a5_5a5a_5a5a);
      issue(KIND_LOCK, ALL_ONES ^ TOP_BIT);
      issue(KIND_QUERY, ALL_ONES ^ 64'd1);
      issue(KIND_QUERY, ALL_ONES);
      issue(KIND_LOCK, ALL_ONES ^ TOP_BIT);
      issue(KIND_UNLOCK, '0);
      issue(KIND_UNLOCK, '0);
      issue(KIND_QUERY, '0);
      issue(KIND_UNLOCK, '0);
      issue(KIND_LOCK, TOP_BIT);
      issue(KIND_LOCK, '0);
      issue(KIND_UNLOCK, ALL_ONES);
      issue(KIND_UNLOCK, ALL_ONES ^ TOP_BIT);
      issue(KIND_UNLOCK, ALL_ONES ^ TOP_BIT);
      issue(KIND_QUERY, ALL_ONES ^ TOP_BIT);
      issue(KIND_UNLOCK, TOP_BIT);

      // random: light sender idling, then heavy, then none
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 14 : (phase == 1) ? 79 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sender_gap();
            issue_random();
         end
      end
      start <= 1'b0;

      // drain, then allow one more transaction time for stray responses
      while (outstanding != 0) @(negedge clock);
      repeat (ENTRIES + 8) @(negedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("refcounted_lock_table test passed");
      else
         $display("refcounted_lock_table test failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/rclt_pkg.sv
rtl/rclt_ctrl.sv
rtl/rclt_data.sv
rtl/refcounted_lock_table.sv
bench/refcounted_lock_table_checker.sv
bench/refcounted_lock_table_tb.sv
